/* src/pwmt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmt_pkg: shared types and codes of the PWM timer
// Payload structs for the command and result channels, command, count mode
// and register index codes.
// ----------------------------------------------------------------------------
package pwmt_pkg;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  channel;
		logic [15:0] duty;
	} pwmt_in_t;

	typedef struct packed {
		logic [15:0] count_value;
		logic [7:0]  pwm_levels;
		logic        overflow_flag;
		logic        irq;
	} pwmt_out_t;

	// Stage load enables handed to the duty scaling pipeline.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} pwmt_adv_t;

	localparam logic [1:0] CMD_TICK       = 2'd0;
	localparam logic [1:0] CMD_DUTY       = 2'd1;
	localparam logic [1:0] CMD_CLEAR_FLAG = 2'd2;

	localparam logic [1:0] MODE_UP     = 2'd0;
	localparam logic [1:0] MODE_UPDOWN = 2'd1;
	localparam logic [1:0] MODE_FREE   = 2'd2;

	localparam logic [2:0] REG_COUNT_MODE    = 3'd0;
	localparam logic [2:0] REG_PERIOD_TOP    = 3'd1;
	localparam logic [2:0] REG_OVF_INTERVAL  = 3'd2;
	localparam logic [2:0] REG_OVF_IRQ_EN    = 3'd3;
	localparam logic [2:0] REG_POLARITY_MASK = 3'd4;
	localparam logic [2:0] REG_CHANNEL_EN    = 3'd5;

	localparam logic [15:0] FREE_MODULO = 16'hFFFF;
	localparam logic [5:0]  INTERVAL_MAX = 6'd32;

endpackage
`default_nettype wire

/* src/pwmt_scale.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwmt_scale: duty to compare value conversion
// Saturates the duty, multiplies by the modulo and divides by the full scale
// through a reciprocal multiply followed by a single correction step.
// ----------------------------------------------------------------------------
module pwmt_scale #(
	parameter int DUTY_FULL_SCALE = 10000
) (
	input  wire logic              clk,
	input  wire logic [15:0]       duty,
	input  wire logic [15:0]       modulo,
	input  wire pwmt_pkg::pwmt_adv_t adv,
	output logic [15:0]            compare
);
	import pwmt_pkg::*;

	localparam logic [15:0] FULL  = 16'(DUTY_FULL_SCALE);
	localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DUTY_FULL_SCALE);

	logic [15:0] duty_sat;
	logic [31:0] prod_s2;
	logic [31:0] prod_s3;
	logic [15:0] q_est_s3;
	logic [15:0] q_s4;
	logic [63:0] est_wide;
	logic [31:0] rem;

	assign duty_sat = (duty > FULL) ? FULL : duty;
	assign est_wide = {32'd0, prod_s2} * {32'd0, RECIP};

	// The estimate is never more than one below the true quotient.
	assign rem = prod_s3 - ({16'd0, q_est_s3} * {16'd0, FULL});

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_s2 <= {16'd0, modulo} * {16'd0, duty_sat};
		end
		if (adv.s3) begin
			prod_s3  <= prod_s2;
			q_est_s3 <= est_wide[47:32];
		end
		if (adv.s4) begin
			q_s4 <= (rem >= {16'd0, FULL}) ? q_est_s3 + 16'd1 : q_est_s3;
		end
	end

	assign compare = q_s4;

endmodule
`default_nettype wire

/* src/pwm_timer_with_overflow_flag_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_timer_with_overflow_flag_core: 16-bit timer with PWM channels
// A command passes the input register, then the multiply, reciprocal multiply and
// correction stages of the duty scaling, then the output register.
// Throughput: one command per cycle unless out_ready stalls; all commands share the same pipeline.
// Reset: counter, flag, tally and all compare values clear; registers return
// to up count, period 0xFFFF, interval 1, interrupt and channels disabled.
// ----------------------------------------------------------------------------
module pwm_timer_with_overflow_flag_core #(
	parameter int CHANNELS        = 8,
	parameter int DUTY_FULL_SCALE = 10000
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pwmt_pkg::pwmt_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output pwmt_pkg::pwmt_out_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [15:0]         cfg_data
);
	import pwmt_pkg::*;

	// Configuration registers
	logic [1:0]  mode_q;
	logic [15:0] period_q;
	logic [5:0]  interval_q;
	logic        irq_en_q;
	logic [7:0]  pol_q;
	logic [7:0]  chan_en_q;

	// Pipeline
	logic       v_s1, v_s2, v_s3, v_s4, out_v_q;
	pwmt_in_t   item_s1;
	logic [1:0] cmd_s2, cmd_s3, cmd_s4;
	logic [2:0] chan_s2, chan_s3, chan_s4;
	logic       free1, free2, free3, free4, free_out;
	pwmt_adv_t  adv;
	logic [15:0] compare_s4;
	logic [15:0] modulo;
	pwmt_out_t  out_q;

	// Timer state
	logic [15:0] counter_q;
	logic        down_q;
	logic [4:0]  tally_q;
	logic        flag_q;
	logic [15:0] pending_q [CHANNELS];
	logic [15:0] active_q  [CHANNELS];

	logic [15:0] counter_d;
	logic        down_d;
	logic [4:0]  tally_d;
	logic        flag_d;
	logic        ovf;
	logic [5:0]  limit;
	logic [5:0]  tally_inc;
	logic [7:0]  levels;
	logic        fire;

	assign free_out = !out_v_q || out_ready;
	assign free4    = !v_s4 || free_out;
	assign free3    = !v_s3 || free4;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_ready = free1;
	assign adv      = '{s2: free2, s3: free3, s4: free4};
	assign fire     = v_s4 && free_out;

	assign cfg_ready = 1'b1;
	assign modulo    = (mode_q == MODE_FREE) ? FREE_MODULO : period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_UP;
			period_q   <= 16'hFFFF;
			interval_q <= 6'd1;
			irq_en_q   <= 1'b0;
			pol_q      <= 8'd0;
			chan_en_q  <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COUNT_MODE:    mode_q     <= cfg_data[1:0];
				REG_PERIOD_TOP:    period_q   <= cfg_data;
				REG_OVF_INTERVAL:  interval_q <= cfg_data[5:0];
				REG_OVF_IRQ_EN:    irq_en_q   <= cfg_data[0];
				REG_POLARITY_MASK: pol_q      <= cfg_data[7:0];
				REG_CHANNEL_EN:    chan_en_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (free1)    v_s1    <= in_valid;
			if (free2)    v_s2    <= v_s1;
			if (free3)    v_s3    <= v_s2;
			if (free4)    v_s4    <= v_s3;
			if (free_out) out_v_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (free1) item_s1 <= in_data;
		if (free2) begin
			cmd_s2  <= item_s1.cmd;
			chan_s2 <= item_s1.channel;
		end
		if (free3) begin
			cmd_s3  <= cmd_s2;
			chan_s3 <= chan_s2;
		end
		if (free4) begin
			cmd_s4  <= cmd_s3;
			chan_s4 <= chan_s3;
		end
	end

	pwmt_scale #(
		.DUTY_FULL_SCALE(DUTY_FULL_SCALE)
	) u_scale (
		.clk    (clk),
		.duty   (item_s1.duty),
		.modulo (modulo),
		.adv    (adv),
		.compare(compare_s4)
	);

	// Next counter state for a tick command.
	always_comb begin
		counter_d = counter_q;
		down_d    = down_q;
		ovf       = 1'b0;
		if (cmd_s4 == CMD_TICK) begin
			if (mode_q == MODE_UPDOWN) begin
				if (modulo == 16'd0) begin
					counter_d = 16'd0;
					down_d    = 1'b0;
					ovf       = 1'b1;
				end else if (!down_q) begin
					if (counter_q >= modulo) begin
						down_d    = 1'b1;
						counter_d = modulo - 16'd1;
						ovf       = 1'b1;
					end else begin
						counter_d = counter_q + 16'd1;
					end
				end else if (counter_q == 16'd0) begin
					down_d    = 1'b0;
					counter_d = 16'd1;
				end else begin
					counter_d = counter_q - 16'd1;
				end
			end else begin
				down_d = 1'b0;
				if (counter_q >= modulo) begin
					counter_d = 16'd0;
					ovf       = 1'b1;
				end else begin
					counter_d = counter_q + 16'd1;
				end
			end
		end
	end

	always_comb begin
		if (interval_q == 6'd0) begin
			limit = 6'd1;
		end else if (interval_q > INTERVAL_MAX) begin
			limit = INTERVAL_MAX;
		end else begin
			limit = interval_q;
		end
		tally_inc = {1'b0, tally_q} + 6'd1;
		tally_d   = tally_q;
		flag_d    = flag_q;
		if (ovf) begin
			if (tally_inc >= limit) begin
				flag_d  = 1'b1;
				tally_d = 5'd0;
			end else begin
				tally_d = tally_inc[4:0];
			end
		end
		if (cmd_s4 == CMD_CLEAR_FLAG) begin
			flag_d = 1'b0;
		end
	end

	// Levels follow the counter and compares as they stand after this command;
	// an overflow loads the pending compares at the same time.
	always_comb begin
		logic [15:0] act;
		levels = 8'd0;
		for (int c = 0; c < CHANNELS; c++) begin
			act = ovf ? pending_q[c] : active_q[c];
			levels[c] = ((counter_d < act) ^ pol_q[c]) & chan_en_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= 16'd0;
			down_q    <= 1'b0;
			tally_q   <= 5'd0;
			flag_q    <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				pending_q[c] <= 16'd0;
				active_q[c]  <= 16'd0;
			end
		end else if (fire) begin
			counter_q <= counter_d;
			down_q    <= down_d;
			tally_q   <= tally_d;
			flag_q    <= flag_d;
			for (int c = 0; c < CHANNELS; c++) begin
				if (ovf) begin
					active_q[c] <= pending_q[c];
				end
				if (cmd_s4 == CMD_DUTY && chan_s4 == 3'(c)) begin
					pending_q[c] <= compare_s4;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.count_value   <= counter_d;
			out_q.pwm_levels    <= levels;
			out_q.overflow_flag <= flag_d;
			out_q.irq           <= flag_d & irq_en_q;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

/* sim/pwm_timer_with_overflow_flag_core_test.sv */
// ----------------------------------------------------------------------------
// pwm_timer_with_overflow_flag_core_test: regression bench for the PWM timer
// Commands are sent through a random-stalling driver and results are taken
// by a random-stalling monitor. An internal timer model predicts each result
// and the monitor compares it field by field. The timer is reprogrammed
// between phases, only once every expected result has arrived.
// ----------------------------------------------------------------------------
module pwm_timer_with_overflow_flag_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pwmt_pkg::*;

	localparam int CHANNELS        = 8;
	localparam int DUTY_FULL_SCALE = 10000;
	localparam int STALL_LIMIT     = 2000;
	localparam int IDLE_PERCENT    = 37;

	// Register indexes past the last register; writes to them are ignored.
	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// The count mode and command codes that the timer leaves unused.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] CMD_SPARE  = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	pwmt_in_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pwmt_out_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	pwmt_in_t    cmd_backlog[$];
	pwmt_out_t   results_due[$];
	int          idle_pct = IDLE_PERCENT;
	int          fault_count = 0;

	// Programmed registers as the timer model sees them.
	logic [1:0]  cf_mode;
	logic [15:0] cf_top;
	logic [5:0]  cf_interval;
	logic        cf_irq_en;
	logic [7:0]  cf_polarity;
	logic [7:0]  cf_enable;

	// Timer model state.
	logic [15:0] tm_count;
	logic        tm_down;
	logic [4:0]  tm_tally;
	logic        tm_flag;
	logic [15:0] tm_pending[CHANNELS];
	logic [15:0] tm_active[CHANNELS];

	pwm_timer_with_overflow_flag_core #(
		.CHANNELS        (CHANNELS),
		.DUTY_FULL_SCALE (DUTY_FULL_SCALE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] modulo_in_force();
		return (cf_mode == MODE_FREE) ? FREE_MODULO : cf_top;
	endfunction

	function automatic void count_overflow();
		int span;
		span = int'(cf_interval);
		if (span == 0) span = 1;
		if (span > int'(INTERVAL_MAX)) span = int'(INTERVAL_MAX);
		tm_active = tm_pending;
		if (int'(tm_tally) + 1 >= span) begin
			tm_flag  = 1'b1;
			tm_tally = '0;
		end else begin
			tm_tally = tm_tally + 5'd1;
		end
	endfunction

	function automatic pwmt_out_t advance_timer(pwmt_in_t item);
		pwmt_out_t   res;
		logic [15:0] top;
		logic [31:0] scaled;
		logic [7:0]  levels;
		logic        lvl;
		int          c;
		top = modulo_in_force();
		case (item.cmd)
		CMD_TICK: begin
			if (cf_mode == MODE_UPDOWN) begin
				if (top == 16'd0) begin
					tm_count = '0;
					tm_down  = 1'b0;
					count_overflow();
				end else if (!tm_down) begin
					if (tm_count >= top) begin
						tm_down  = 1'b1;
						tm_count = top - 16'd1;
						count_overflow();
					end else begin
						tm_count = tm_count + 16'd1;
					end
				end else if (tm_count == 16'd0) begin
					tm_down  = 1'b0;
					tm_count = 16'd1;
				end else begin
					tm_count = tm_count - 16'd1;
				end
			end else begin
				// Free running and the unused mode both count up and wrap.
				tm_down = 1'b0;
				if (tm_count >= top) begin
					tm_count = '0;
					count_overflow();
				end else begin
					tm_count = tm_count + 16'd1;
				end
			end
		end
		CMD_DUTY: begin
			if (int'(item.channel) < CHANNELS) begin
				scaled = (item.duty > DUTY_FULL_SCALE) ? DUTY_FULL_SCALE : item.duty;
				scaled = (32'(top) * scaled) / DUTY_FULL_SCALE;
				tm_pending[item.channel] = scaled[15:0];
			end
		end
		CMD_CLEAR_FLAG: tm_flag = 1'b0;
		default: ;
		endcase
		levels = '0;
		for (c = 0; c < CHANNELS; c++) begin
			lvl = (tm_count < tm_active[c]);
			if (cf_polarity[c]) lvl = ~lvl;
			if (!cf_enable[c]) lvl = 1'b0;
			levels[c] = lvl;
		end
		res.count_value   = tm_count;
		res.pwm_levels    = levels;
		res.overflow_flag = tm_flag;
		res.irq           = tm_flag & cf_irq_en;
		return res;
	endfunction

	function automatic pwmt_in_t make_cmd(logic [1:0] op, logic [2:0] ch, logic [15:0] duty);
		pwmt_in_t item;
		item.cmd     = op;
		item.channel = ch;
		item.duty    = duty;
		return item;
	endfunction

	// Command driver: presents queued commands, idling at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(advance_timer(in_data));
			if (!in_valid || in_ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= cmd_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks every result transfer against the oldest prediction.
	always @(posedge clk) begin
		pwmt_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					fault_count++;
					$display("%0t: result expected none, actual %h", $time, out_data);
				end else begin
					want = results_due.pop_front();
					if (out_data.count_value !== want.count_value) begin
						fault_count++;
						$display("%0t: count_value expected %h actual %h", $time,
							want.count_value, out_data.count_value);
					end
					if (out_data.pwm_levels !== want.pwm_levels) begin
						fault_count++;
						$display("%0t: pwm_levels expected %b actual %b", $time,
							want.pwm_levels, out_data.pwm_levels);
					end
					if (out_data.overflow_flag !== want.overflow_flag) begin
						fault_count++;
						$display("%0t: overflow_flag expected %b actual %b", $time,
							want.overflow_flag, out_data.overflow_flag);
					end
					if (out_data.irq !== want.irq) begin
						fault_count++;
						$display("%0t: irq expected %b actual %b", $time,
							want.irq, out_data.irq);
					end
				end
			end
			out_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// Ends the run if no transfer of any kind happens for too long.
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("pwm_timer_with_overflow_flag_core regression: fail");
		$finish;
	end

	// Called just after a rising edge; leaves cfg_valid high so that writes
	// can follow back to back.
	task automatic write_reg(logic [2:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_COUNT_MODE:    cf_mode     = value[1:0];
		REG_PERIOD_TOP:    cf_top      = value;
		REG_OVF_INTERVAL:  cf_interval = value[5:0];
		REG_OVF_IRQ_EN:    cf_irq_en   = value[0];
		REG_POLARITY_MASK: cf_polarity = value[7:0];
		REG_CHANNEL_EN:    cf_enable   = value[7:0];
		default: ;
		endcase
	endtask

	task automatic program_timer(logic [1:0] mode_v, logic [15:0] top_v, logic [5:0] ivl_v,
			logic irq_v, logic [7:0] pol_v, logic [7:0] en_v);
		write_reg(REG_COUNT_MODE, 16'(mode_v));
		write_reg(REG_PERIOD_TOP, top_v);
		write_reg(REG_OVF_INTERVAL, 16'(ivl_v));
		write_reg(REG_OVF_IRQ_EN, 16'(irq_v));
		write_reg(REG_POLARITY_MASK, 16'(pol_v));
		write_reg(REG_CHANNEL_EN, 16'(en_v));
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued command has been transferred and answered.
	// The queues and the driver's valid are looked at on the falling edge, once
	// the updates of the rising edge have all settled.
	task automatic await_drain();
		do @(negedge clk);
		while (cmd_backlog.size() != 0 || in_valid || results_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin : sequencer
		pwmt_in_t    item;
		logic [1:0]  pick_mode;
		logic [15:0] pick_top;
		logic [5:0]  pick_ivl;
		logic        pick_irq;
		logic [7:0]  pick_pol;
		logic [7:0]  pick_en;
		int          phase;
		int          k;
		int          roll;

		cf_mode     = MODE_UP;
		cf_top      = 16'hFFFF;
		cf_interval = 6'd1;
		cf_irq_en   = 1'b0;
		cf_polarity = '0;
		cf_enable   = '0;
		tm_count    = '0;
		tm_down     = 1'b0;
		tm_tally    = '0;
		tm_flag     = 1'b0;
		for (k = 0; k < CHANNELS; k++) begin
			tm_pending[k] = '0;
			tm_active[k]  = '0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: saturated and zero duty, a tick, the
		// unused command and a flag clear.
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd7, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd0, 16'd0));
		cmd_backlog.push_back(make_cmd(CMD_TICK, 3'd5, 16'hAAAA));
		cmd_backlog.push_back(make_cmd(CMD_SPARE, 3'd2, 16'h5555));
		cmd_backlog.push_back(make_cmd(CMD_CLEAR_FLAG, 3'd0, 16'd0));
		await_drain();

		// Short edge-aligned period with duty extremes on every channel; the
		// new compares only take effect at the wrap.
		write_reg(REG_SPARE_LO, 16'hFFFF);
		write_reg(REG_SPARE_HI, 16'h1234);
		program_timer(MODE_UP, 16'd3, 6'd1, 1'b1, 8'hA5, 8'hFF);
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd0, 16'd0));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd1, 16'd1));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd2, 16'd5000));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd3, 16'd9999));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd4, 16'd10000));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd5, 16'd10001));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd6, 16'hFFFF));
		cmd_backlog.push_back(make_cmd(CMD_DUTY, 3'd7, 16'd3333));
		for (k = 0; k < 4; k++)
			cmd_backlog.push_back(make_cmd(CMD_TICK, 3'd0, 16'd0));
		cmd_backlog.push_back(make_cmd(CMD_CLEAR_FLAG, 3'd0, 16'd0));
		await_drain();

		// Up-down with a zero modulo overflows on every tick; interval zero acts as one.
		program_timer(MODE_UPDOWN, 16'd0, 6'd0, 1'b1, 8'h00, 8'h0F);
		cmd_backlog.push_back(make_cmd(CMD_TICK, 3'd0, 16'd0));
		cmd_backlog.push_back(make_cmd(CMD_TICK, 3'd0, 16'd0));
		cmd_backlog.push_back(make_cmd(CMD_CLEAR_FLAG, 3'd0, 16'd0));
		await_drain();

		// The unused mode counts as edge aligned; an interval above the maximum is clipped.
		program_timer(MODE_SPARE, 16'd2, 6'd63, 1'b0, 8'hFF, 8'hF0);
		for (k = 0; k < 4; k++)
			cmd_backlog.push_back(make_cmd(CMD_TICK, 3'd0, 16'd0));
		await_drain();

		for (phase = 0; phase < 8; phase++) begin
			roll = $urandom_range(0, 9);
			pick_mode = (roll < 4) ? MODE_UP : (roll < 7) ? MODE_UPDOWN :
				(roll < 9) ? MODE_FREE : MODE_SPARE;
			roll = $urandom_range(0, 9);
			pick_top = (roll == 0) ? 16'd0 : (roll == 1) ? 16'hFFFF :
				(roll == 2) ? 16'($urandom) : 16'($urandom_range(1, 40));
			roll = $urandom_range(0, 9);
			pick_ivl = (roll == 0) ? 6'd0 : (roll == 1) ? 6'($urandom_range(33, 63)) :
				(roll == 2) ? INTERVAL_MAX : 6'($urandom_range(1, 6));
			pick_irq = 1'($urandom);
			pick_pol = 8'($urandom);
			pick_en  = 8'($urandom);
			if (phase == 0) begin
				pick_mode = MODE_UPDOWN;
				pick_top  = 16'd1;
				pick_ivl  = INTERVAL_MAX;
				pick_irq  = 1'b1;
				pick_pol  = 8'hFF;
				pick_en   = 8'hFF;
			end else if (phase == 7) begin
				pick_mode = MODE_UP;
				pick_top  = 16'hFFFF;
				pick_ivl  = 6'd1;
				pick_irq  = 1'b0;
				pick_pol  = 8'h00;
				pick_en   = 8'h00;
			end
			// One phase runs with no idling on either side.
			idle_pct = (phase == 3) ? 0 : IDLE_PERCENT;
			program_timer(pick_mode, pick_top, pick_ivl, pick_irq, pick_pol, pick_en);
			for (k = 0; k < 131; k++) begin
				item.channel = 3'($urandom);
				roll = $urandom_range(0, 9);
				item.duty = (roll == 0) ? 16'($urandom) : (roll == 1) ? 16'd10000 :
					(roll == 2) ? 16'd0 : 16'($urandom_range(0, DUTY_FULL_SCALE));
				roll = $urandom_range(0, 99);
				item.cmd = (roll < 68) ? CMD_TICK : (roll < 88) ? CMD_DUTY :
					(roll < 97) ? CMD_CLEAR_FLAG : CMD_SPARE;
				cmd_backlog.push_back(item);
			end
			await_drain();
		end

		repeat (10) @(posedge clk);
		if (fault_count == 0 && results_due.size() == 0) begin
			$display("pwm_timer_with_overflow_flag_core regression: pass");
		end else begin
			$display("pwm_timer_with_overflow_flag_core regression: fail");
		end
		$finish;
	end

endmodule
